[design/uer_pkg.sv]
`timescale 1ns / 1ps

package uer_pkg;

  // Register and field widths
  localparam int unsigned TEMP_W     = 8;
  localparam int unsigned ROUNDS_W   = 8;
  localparam int unsigned TRIG_W     = 8;
  localparam int unsigned WAIT_W     = 17;
  localparam int unsigned PULSE_W    = 15;
  localparam int unsigned HOLD_W     = 18;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 18;

  // Datapath widths
  localparam int unsigned CNT_W   = 18;
  localparam int unsigned SUM_W   = 23;
  localparam int unsigned SPEED_W = 19;
  localparam int unsigned PROD_W  = SUM_W + SPEED_W;
  localparam int unsigned DVSR_W  = 19;
  localparam int unsigned AVG_W   = 15;
  localparam int unsigned DIST_W  = 22;

  // Fixed limits
  localparam int unsigned MAX_ROUNDS       = 255;
  localparam int unsigned TEMP_TABLE_DEPTH = 128;
  localparam int          TEMP_MIN         = -40;
  localparam int          TEMP_MAX         = 85;
  localparam int unsigned DIST_MAX         = 3800000;
  // round trip, us times mm/s to um: divide by 2 * 1000
  localparam int unsigned HALF_TRIP_DIV    = 2000;

  // Register reset values
  localparam int          TEMP_RST   = 25;
  localparam int unsigned ROUNDS_RST = 5;
  localparam int unsigned TRIG_RST   = 10;
  localparam int unsigned WAIT_RST   = 100000;
  localparam int unsigned PULSE_RST  = 20000;
  localparam int unsigned HOLD_RST   = 200000;

  // Speed of sound: 20046.796 * sqrt(273.15 + T) mm/s, fixed point
  localparam longint unsigned KELVIN_CENTI = 64'd27315;
  localparam longint unsigned SQRT_SCALE   = 64'd10000000000;
  localparam longint unsigned SOUND_COEF   = 64'd20046796;
  localparam longint unsigned SOUND_ROUND  = 64'd500000000;
  localparam longint unsigned SOUND_DIV    = 64'd1000000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP   = 3'd0,
    REG_ROUNDS = 3'd1,
    REG_TRIG   = 3'd2,
    REG_WAIT   = 3'd3,
    REG_PULSE  = 3'd4,
    REG_HOLD   = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CNT_KEEP = 2'd0,
    CNT_CLR  = 2'd1,
    CNT_ONE  = 2'd2,
    CNT_INC  = 2'd3
  } cnt_op_e;

  typedef enum logic [1:0] {
    W_KEEP = 2'd0,
    W_CLR  = 2'd1,
    W_ONE  = 2'd2,
    W_INC  = 2'd3
  } width_op_e;

  typedef enum logic {
    DIV_AVG  = 1'b0,
    DIV_DIST = 1'b1
  } div_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic      burst_clr;
    cnt_op_e   cnt_op;
    width_op_e width_op;
    logic      sum_add;
    logic      rounds_inc;
    logic      missed_set;
    logic      look;
    logic      div_start;
    div_sel_e  div_sel;
    logic      avg_cap;
    logic      out_tick;
    logic      out_res;
    logic      out_trig;
    logic      out_busy;
  } uer_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic trig_done;
    logic wait_expire;
    logic meas_more;
    logic hold_done;
    logic holdoff_zero;
    logic last_after_inc;
    logic last_now;
    logic div_busy;
    logic out_free;
  } uer_stat_t;

  // Evaluated at elaboration only, to fill the speed table
  function automatic logic [31:0] speed_for(input int t_c);
    longint unsigned centi;
    longint unsigned v;
    longint unsigned res;
    longint unsigned bitv;
    longint unsigned rnd;
    centi = KELVIN_CENTI + 64'(100 * t_c);
    v     = centi * SQRT_SCALE;
    res   = 64'd0;
    bitv  = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    rnd = SOUND_COEF * res + SOUND_ROUND;
    return 32'(rnd / SOUND_DIV);
  endfunction

endpackage

[design/uer_if.sv]
`timescale 1ns / 1ps

// Tick word: one per microsecond
interface uer_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic echo_level;

  modport source (output valid, output start_req, output echo_level, input ready);
  modport sink   (input valid, input start_req, input echo_level, output ready);
endinterface

// Result word: one per accepted tick
interface uer_out_if;
  import uer_pkg::*;
  logic              valid;
  logic              ready;
  logic              trigger_out;
  logic              busy_res;
  logic              result_valid;
  logic [AVG_W-1:0]  avg_echo_us;
  logic [DIST_W-1:0] distance_um;
  logic              timed_out;

  modport source (output valid, output trigger_out, output busy_res, output result_valid,
                  output avg_echo_us, output distance_um, output timed_out, input ready);
  modport sink   (input valid, input trigger_out, input busy_res, input result_valid,
                  input avg_echo_us, input distance_um, input timed_out, output ready);
endinterface

// Register write channel
interface uer_cfg_if;
  import uer_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[design/uer_div.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle
module uer_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [uer_pkg::PROD_W-1:0] dividend_i,
  input  logic [uer_pkg::DVSR_W-1:0] divisor_i,
  output logic                       busy_o,
  output logic [uer_pkg::PROD_W-1:0] quotient_o
);
  import uer_pkg::*;

  localparam int unsigned StepW = $clog2(PROD_W + 1);

  logic              busy_q;
  logic [StepW-1:0]  step_q;
  logic [PROD_W-1:0] quo_q;
  logic [DVSR_W-1:0] rem_q;
  logic [DVSR_W-1:0] dvsr_q;

  logic [DVSR_W:0]   trial;
  logic [DVSR_W:0]   diff;
  logic              fits;
  logic [DVSR_W-1:0] rem_d;

  // Trial subtract of the shifted partial remainder
  always_comb begin
    trial = {rem_q, quo_q[PROD_W-1]};
    diff  = trial - {1'b0, dvsr_q};
    fits  = trial >= {1'b0, dvsr_q};
    rem_d = fits ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= StepW'(PROD_W);
    end else if (busy_q) begin
      step_q <= step_q - StepW'(1);
      if (step_q == StepW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Quotient shifts in from the right as the dividend shifts out
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q  <= dividend_i;
      rem_q  <= '0;
      dvsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[PROD_W-2:0], fits};
      rem_q <= rem_d;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

[design/uer_dp.sv]
`timescale 1ns / 1ps

module uer_dp #(
  parameter int unsigned TempTableDepth = uer_pkg::TEMP_TABLE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  uer_cfg_if.sink            cfg_ch,
  uer_out_if.source          out_ch,
  input  uer_pkg::uer_cmd_t  cmd_i,
  output uer_pkg::uer_stat_t stat_o
);
  import uer_pkg::*;

  localparam int unsigned IdxW = $clog2(TempTableDepth);
  localparam logic signed [TEMP_W-1:0] TempLo = TEMP_W'(TEMP_MIN);
  localparam logic signed [TEMP_W-1:0] TempHi = TEMP_W'(TEMP_MAX);
  localparam logic [7:0] IdxTop = 8'(TempTableDepth - 1);

  // Configuration registers
  logic signed [TEMP_W-1:0] temp_q;
  logic [ROUNDS_W-1:0]      rounds_q;
  logic [TRIG_W-1:0]        trig_q;
  logic [WAIT_W-1:0]        wait_q;
  logic [PULSE_W-1:0]       pulse_q;
  logic [HOLD_W-1:0]        hold_q;

  // Burst state
  logic [CNT_W-1:0]    cnt_q;
  logic [ROUNDS_W-1:0] rounds_done_q;
  logic [PULSE_W-1:0]  width_q;
  logic [SUM_W-1:0]    sum_q;
  logic                missed_q;

  // Report arithmetic
  logic [SPEED_W-1:0] speed_q;
  logic [DVSR_W-1:0]  dvsr2k_q;
  logic [PROD_W-1:0]  prod_q;
  logic [AVG_W-1:0]   avg_q;

  // Output register
  logic              out_valid_q;
  logic              trig_out_q;
  logic              busy_out_q;
  logic              res_valid_q;
  logic [AVG_W-1:0]  avg_out_q;
  logic [DIST_W-1:0] dist_out_q;
  logic              tout_out_q;

  logic [CNT_W-1:0]    cnt_inc;
  logic [PULSE_W-1:0]  cap;
  logic [ROUNDS_W-1:0] rounds_nz;
  logic [ROUNDS_W-1:0] eff_rounds;
  logic [ROUNDS_W-1:0] rounds_inc;
  logic [ROUNDS_W-1:0] n_div;
  logic signed [TEMP_W-1:0] temp_clamp;
  logic [7:0]          idx_raw;
  logic [7:0]          idx_cap;
  logic [IdxW-1:0]     idx;
  logic [PROD_W-1:0]   prod_d;
  logic [PROD_W-1:0]   div_dividend;
  logic [DVSR_W-1:0]   div_divisor;
  logic                div_busy;
  logic [PROD_W-1:0]   div_quo;
  logic [DIST_W-1:0]   dist_sat;
  logic                out_free;

  // Speed table, one entry per degree from the lowest temperature up
  logic [SPEED_W-1:0] speed_tab [TempTableDepth];

  for (genvar g = 0; g < TempTableDepth; g++) begin : g_speed
    localparam logic [SPEED_W-1:0] SpeedVal = SPEED_W'(speed_for(g + TEMP_MIN));
    assign speed_tab[g] = SpeedVal;
  end

  // Register writes; the port never stalls
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q   <= TEMP_W'(TEMP_RST);
      rounds_q <= ROUNDS_W'(ROUNDS_RST);
      trig_q   <= TRIG_W'(TRIG_RST);
      wait_q   <= WAIT_W'(WAIT_RST);
      pulse_q  <= PULSE_W'(PULSE_RST);
      hold_q   <= HOLD_W'(HOLD_RST);
    end else if (cfg_ch.valid) begin
      case (cfg_reg_e'(cfg_ch.index))
        REG_TEMP:   temp_q   <= cfg_ch.data[TEMP_W-1:0];
        REG_ROUNDS: rounds_q <= cfg_ch.data[ROUNDS_W-1:0];
        REG_TRIG:   trig_q   <= cfg_ch.data[TRIG_W-1:0];
        REG_WAIT:   wait_q   <= cfg_ch.data[WAIT_W-1:0];
        REG_PULSE:  pulse_q  <= cfg_ch.data[PULSE_W-1:0];
        REG_HOLD:   hold_q   <= cfg_ch.data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Status compares for the controller
  always_comb begin
    cnt_inc    = cnt_q + CNT_W'(1);
    cap        = (pulse_q == '0) ? PULSE_W'(1) : pulse_q;
    rounds_nz  = (rounds_q == '0) ? ROUNDS_W'(1) : rounds_q;
    eff_rounds = (rounds_nz > ROUNDS_W'(MAX_ROUNDS)) ? ROUNDS_W'(MAX_ROUNDS) : rounds_nz;
    rounds_inc = rounds_done_q + ROUNDS_W'(1);

    stat_o.trig_done      = cnt_q >= CNT_W'(trig_q);
    stat_o.wait_expire    = cnt_inc >= CNT_W'(wait_q);
    stat_o.meas_more      = width_q < cap;
    stat_o.hold_done      = cnt_inc >= hold_q;
    stat_o.holdoff_zero   = hold_q == '0;
    stat_o.last_after_inc = rounds_inc >= eff_rounds;
    stat_o.last_now       = rounds_done_q >= eff_rounds;
    stat_o.div_busy       = div_busy;
    stat_o.out_free       = out_free;
  end

  // Phase counter, echo width and burst accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q         <= '0;
      width_q       <= '0;
      sum_q         <= '0;
      rounds_done_q <= '0;
      missed_q      <= 1'b0;
    end else begin
      case (cmd_i.cnt_op)
        CNT_CLR: cnt_q <= '0;
        CNT_ONE: cnt_q <= CNT_W'(1);
        CNT_INC: cnt_q <= cnt_inc;
        default: ;
      endcase
      case (cmd_i.width_op)
        W_CLR:   width_q <= '0;
        W_ONE:   width_q <= PULSE_W'(1);
        W_INC:   width_q <= width_q + PULSE_W'(1);
        default: ;
      endcase
      if (cmd_i.burst_clr) begin
        sum_q         <= '0;
        rounds_done_q <= '0;
        missed_q      <= 1'b0;
      end else begin
        if (cmd_i.sum_add) begin
          sum_q <= sum_q + SUM_W'(width_q);
        end
        if (cmd_i.rounds_inc) begin
          rounds_done_q <= rounds_inc;
        end
        if (cmd_i.missed_set) begin
          missed_q <= 1'b1;
        end
      end
    end
  end

  // Table index: clamp the temperature, then cap at the table end
  always_comb begin
    if (temp_q < TempLo) begin
      temp_clamp = TempLo;
    end else if (temp_q > TempHi) begin
      temp_clamp = TempHi;
    end else begin
      temp_clamp = temp_q;
    end
    idx_raw = temp_clamp - TempLo;
    idx_cap = (idx_raw > IdxTop) ? IdxTop : idx_raw;
    idx     = idx_cap[IdxW-1:0];
    n_div   = (rounds_done_q == '0) ? ROUNDS_W'(1) : rounds_done_q;
    prod_d  = PROD_W'(sum_q) * PROD_W'(speed_q);
  end

  // Speed lookup, scaled divisor and width-sum product
  always_ff @(posedge clk_i) begin
    if (cmd_i.look) begin
      speed_q  <= speed_tab[idx];
      dvsr2k_q <= DVSR_W'(n_div) * DVSR_W'(HALF_TRIP_DIV);
    end
    prod_q <= prod_d;
    if (cmd_i.avg_cap) begin
      avg_q <= div_quo[AVG_W-1:0];
    end
  end

  // Shared divider: average first, then distance
  always_comb begin
    if (cmd_i.div_sel == DIV_AVG) begin
      div_dividend = PROD_W'(sum_q);
      div_divisor  = DVSR_W'(n_div);
    end else begin
      div_dividend = prod_q;
      div_divisor  = dvsr2k_q;
    end
    dist_sat = (div_quo > PROD_W'(DIST_MAX)) ? DIST_W'(DIST_MAX) : div_quo[DIST_W-1:0];
  end

  uer_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  // Output register
  assign out_free = !out_valid_q || out_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_tick || cmd_i.out_res) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_tick) begin
      trig_out_q  <= cmd_i.out_trig;
      busy_out_q  <= cmd_i.out_busy;
      res_valid_q <= 1'b0;
      avg_out_q   <= '0;
      dist_out_q  <= '0;
      tout_out_q  <= 1'b0;
    end else if (cmd_i.out_res) begin
      trig_out_q  <= 1'b0;
      busy_out_q  <= 1'b0;
      res_valid_q <= 1'b1;
      avg_out_q   <= avg_q;
      dist_out_q  <= dist_sat;
      tout_out_q  <= missed_q;
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.trigger_out  = trig_out_q;
  assign out_ch.busy_res     = busy_out_q;
  assign out_ch.result_valid = res_valid_q;
  assign out_ch.avg_echo_us  = avg_out_q;
  assign out_ch.distance_um  = dist_out_q;
  assign out_ch.timed_out    = tout_out_q;

endmodule

[design/uer_ctrl.sv]
`timescale 1ns / 1ps

module uer_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  uer_in_if.sink             in_ch,
  input  uer_pkg::uer_stat_t stat_i,
  output uer_pkg::uer_cmd_t  cmd_o
);
  import uer_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_TRIG = 5'b00010,
    PH_WAIT = 5'b00100,
    PH_MEAS = 5'b01000,
    PH_HOLD = 5'b10000
  } phase_e;

  typedef enum logic [3:0] {
    SQ_RUN   = 4'b0001,
    SQ_LOOK  = 4'b0010,
    SQ_DAVG  = 4'b0100,
    SQ_DDIST = 4'b1000
  } seq_e;

  phase_e phase_q, phase_d;
  seq_e   seq_q, seq_d;

  logic tick;
  logic go_next;
  logic last_sel;
  logic rpt;

  assign in_ch.ready = (seq_q == SQ_RUN) && stat_i.out_free;
  assign tick        = in_ch.valid && in_ch.ready;

  always_comb begin
    phase_d  = phase_q;
    seq_d    = seq_q;
    cmd_o    = '0;
    go_next  = 1'b0;
    last_sel = 1'b0;
    rpt      = 1'b0;

    // Ranging phases, one step per accepted tick
    if (tick) begin
      case (phase_q)
        PH_IDLE: begin
          if (in_ch.start_req) begin
            cmd_o.burst_clr = 1'b1;
            cmd_o.cnt_op    = CNT_ONE;
            cmd_o.width_op  = W_CLR;
            phase_d         = PH_TRIG;
          end
        end
        PH_TRIG: begin
          if (stat_i.trig_done) begin
            cmd_o.cnt_op = CNT_CLR;
            phase_d      = PH_WAIT;
          end else begin
            cmd_o.cnt_op = CNT_INC;
          end
        end
        PH_WAIT: begin
          if (in_ch.echo_level) begin
            cmd_o.width_op = W_ONE;
            cmd_o.cnt_op   = CNT_CLR;
            phase_d        = PH_MEAS;
          end else if (stat_i.wait_expire) begin
            // no echo: round counts as zero width, no holdoff
            cmd_o.missed_set = 1'b1;
            cmd_o.width_op   = W_CLR;
            cmd_o.rounds_inc = 1'b1;
            go_next          = 1'b1;
            last_sel         = stat_i.last_after_inc;
          end else begin
            cmd_o.cnt_op = CNT_INC;
          end
        end
        PH_MEAS: begin
          if (in_ch.echo_level && stat_i.meas_more) begin
            cmd_o.width_op = W_INC;
          end else begin
            cmd_o.sum_add    = 1'b1;
            cmd_o.rounds_inc = 1'b1;
            if (!stat_i.holdoff_zero) begin
              cmd_o.cnt_op = CNT_CLR;
              phase_d      = PH_HOLD;
            end else begin
              go_next  = 1'b1;
              last_sel = stat_i.last_after_inc;
            end
          end
        end
        PH_HOLD: begin
          if (stat_i.hold_done) begin
            go_next  = 1'b1;
            last_sel = stat_i.last_now;
          end else begin
            cmd_o.cnt_op = CNT_INC;
          end
        end
        default: begin
          cmd_o.cnt_op = CNT_CLR;
          phase_d      = PH_IDLE;
        end
      endcase

      // Next ping, or report when the burst is complete
      if (go_next) begin
        if (last_sel) begin
          cmd_o.cnt_op = CNT_CLR;
          phase_d      = PH_IDLE;
          rpt          = 1'b1;
        end else begin
          cmd_o.cnt_op   = CNT_ONE;
          cmd_o.width_op = W_CLR;
          phase_d        = PH_TRIG;
        end
      end

      if (rpt) begin
        seq_d = SQ_LOOK;
      end else begin
        cmd_o.out_tick = 1'b1;
        cmd_o.out_trig = phase_d == PH_TRIG;
        cmd_o.out_busy = phase_d != PH_IDLE;
      end
    end

    // Report sequence: lookup, average divide, distance divide, output
    case (seq_q)
      SQ_RUN: ;
      SQ_LOOK: begin
        cmd_o.look      = 1'b1;
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_AVG;
        seq_d           = SQ_DAVG;
      end
      SQ_DAVG: begin
        if (!stat_i.div_busy) begin
          cmd_o.avg_cap   = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_DIST;
          seq_d           = SQ_DDIST;
        end
      end
      SQ_DDIST: begin
        cmd_o.div_sel = DIV_DIST;
        if (!stat_i.div_busy && stat_i.out_free) begin
          cmd_o.out_res = 1'b1;
          seq_d         = SQ_RUN;
        end
      end
      default: seq_d = SQ_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      seq_q   <= SQ_RUN;
    end else begin
      phase_q <= phase_d;
      seq_q   <= seq_d;
    end
  end

endmodule

[design/ultrasonic_echo_ranger.sv]
`timescale 1ns / 1ps

// Channel   Dir  Word                                        Handshake
// in_ch     in   start_req, echo_level (one microsecond tick) valid/ready
// out_ch    out  trigger_out, busy_res, result_valid,         valid/ready
//                avg_echo_us, distance_um, timed_out
// cfg_ch    in   index (register number), data                valid/ready, never stalls
//
// The tick that ends a burst starts the report: speed lookup, then the bit-serial divider
// computes the average and then the distance before the result word is loaded; in_ch.ready
// stays low until then.
// Reset (rst_ni low, asynchronous) sets the registers to their defaults and the ranger idle.
// A stalled output holds in_ch.ready low until the result register frees up.

module ultrasonic_echo_ranger #(
  parameter int unsigned TempTableDepth = uer_pkg::TEMP_TABLE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  uer_in_if.sink    in_ch,
  uer_out_if.source out_ch,
  uer_cfg_if.sink   cfg_ch
);
  import uer_pkg::*;

  uer_cmd_t  cmd;
  uer_stat_t stat;

  uer_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  uer_dp #(
    .TempTableDepth (TempTableDepth)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

endmodule

[design/uer_chk.sv]
`timescale 1ns / 1ps

module uer_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       valid_i,
  input logic                       ready_i,
  input logic                       trigger_out_i,
  input logic                       busy_res_i,
  input logic                       result_valid_i,
  input logic [uer_pkg::AVG_W-1:0]  avg_echo_us_i,
  input logic [uer_pkg::DIST_W-1:0] distance_um_i,
  input logic                       timed_out_i
);
  import uer_pkg::*;

  // Result fields are zero on ordinary tick words
  a_zero_off_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !result_valid_i |-> avg_echo_us_i == '0 && distance_um_i == '0 && !timed_out_i)
    else $error("result fields set on a non-report word");

  // The report word shows the burst finished
  a_report_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && result_valid_i |-> !busy_res_i && !trigger_out_i)
    else $error("report word shows busy or trigger");

  // Trigger only inside a burst
  a_trig_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && trigger_out_i |-> busy_res_i)
    else $error("trigger high while not busy");

  // Distance saturates
  a_dist_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> distance_um_i <= DIST_W'(DIST_MAX))
    else $error("distance above saturation limit");

  // A stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable({trigger_out_i, busy_res_i, result_valid_i,
                                                avg_echo_us_i, distance_um_i, timed_out_i}))
    else $error("output word changed while stalled");

endmodule

bind ultrasonic_echo_ranger uer_chk u_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .valid_i        (out_ch.valid),
  .ready_i        (out_ch.ready),
  .trigger_out_i  (out_ch.trigger_out),
  .busy_res_i     (out_ch.busy_res),
  .result_valid_i (out_ch.result_valid),
  .avg_echo_us_i  (out_ch.avg_echo_us),
  .distance_um_i  (out_ch.distance_um),
  .timed_out_i    (out_ch.timed_out)
);
